// ===== sv/bptc_pkg.sv =====
// Shared types and constants for the barometric temperature/pressure compensation block.
// No dependencies; the top, front, back, divider and testbench import this package.
package bptc_pkg;

	typedef enum logic [1:0] {
		REG_TEMP_CALIB  = 2'd0,
		REG_PRESS_CAL_A = 2'd1,
		REG_PRESS_CAL_B = 2'd2,
		REG_PRESS_P9    = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [23:0] raw_temperature;
		logic [23:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic signed [31:0] fine_temperature;
		logic        [15:0] pressure_hpa;
		logic               divide_error;
	} result_t;

	typedef struct packed {
		reg_index_t  index;
		logic [63:0] wdata;
	} cfg_write_t;

	// calibration words as the datapath sees them
	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} calib_t;

	// temperature results waiting for the pressure path
	typedef struct packed {
		logic signed [31:0] fine;
		logic signed [15:0] tc;
		logic        [20:0] pp;
	} queue_entry_t;

	localparam int DIV_STAGES = 64;
	localparam logic [63:0] FINE_OFFSET = 64'd128000;
	localparam logic [20:0] ADC_FULL    = 21'd1048576;
	localparam logic [63:0] SCALE_3125  = 64'd3125;
	localparam logic [63:0] ONE_SHL47   = 64'h0000_8000_0000_0000;
	localparam logic [63:0] HPA_SAT_PA  = 64'd1677721600;
	// ceil(2^26 / 25): exact quotient for values below 2^21
	localparam logic [21:0] RECIP_25    = 22'd2684355;

endpackage

// ===== sv/bptc_stream_if.sv =====
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from bptc_pkg at the instance.
interface bptc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/baro_temp_pressure_compensation_top.sv =====
// Top level: calibration registers, front end, queue, pressure back end.
// Depends on bptc_pkg, bptc_stream_if, bptc_front and bptc_back.
//
//  port      dir   payload        moves
//  samples   in    sample_t       raw temperature and pressure burst
//  results   out   result_t       temperature, fine value, hPa, divide flag
//  cfg       in    cfg_write_t    calibration register write
//
// One sample pair is taken per cycle while the front is not held; a sample passes
// through the front registers, the queue and the back, whose divider yields one
// quotient bit per stage. Reset clears valid bits, queue pointers and calibration.
// A stalled result holds the back end; the queue then fills and holds the front.
module baro_temp_pressure_compensation_top
	import bptc_pkg::*;
#(
	parameter int QueueDepth = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	bptc_stream_if.sink   samples,
	bptc_stream_if.source results,
	bptc_stream_if.sink   cfg
);
	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	logic [47:0]  temp_calib_q;
	logic [63:0]  press_a_q;
	logic [63:0]  press_b_q;
	logic [15:0]  press_p9_q;
	calib_t       calib;
	logic         push, pop, queue_full;
	queue_entry_t push_data;
	queue_entry_t queue_mem [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] q_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_p9_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_TEMP_CALIB:  temp_calib_q <= cfg.data.wdata[47:0];
				REG_PRESS_CAL_A: press_a_q    <= cfg.data.wdata;
				REG_PRESS_CAL_B: press_b_q    <= cfg.data.wdata;
				REG_PRESS_P9:    press_p9_q   <= cfg.data.wdata[15:0];
				default: ;
			endcase
		end
	end

	assign calib = '{t1: temp_calib_q[15:0], t2: temp_calib_q[31:16],
		t3: temp_calib_q[47:32], p1: press_a_q[15:0], p2: press_a_q[31:16],
		p3: press_a_q[47:32], p4: press_a_q[63:48], p5: press_b_q[15:0],
		p6: press_b_q[31:16], p7: press_b_q[47:32], p8: press_b_q[63:48],
		p9: press_p9_q};

	bptc_front u_front (
		.clk, .arst_n, .samples, .calib, .queue_full, .push, .push_data
	);

	assign queue_full = (q_count_q == CntW'(QueueDepth));

	always_ff @(posedge clk) begin
		if (push) begin
			queue_mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			q_count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			q_count_q <= q_count_q + CntW'(push) - CntW'(pop);
		end
	end

	bptc_back u_back (
		.clk, .arst_n, .calib,
		.queue_valid(q_count_q != '0), .queue_data(queue_mem[rd_ptr_q]),
		.pop, .results
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count_q <= CntW'(QueueDepth))
		else $error("request queue count exceeds its depth");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> queue_full)
		else $error("input held off while the queue has room");

	a_div_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.divide_error |-> results.data.pressure_hpa == '0)
		else $error("zero divisor result carries nonzero pressure");
endmodule

// ===== sv/bptc_mul64.sv =====
// 64x64 multiply modulo 2^64 built from three 32x32 products, two register stages.
// Depends on nothing.
module bptc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end

	assign p = p_s2;
endmodule

// ===== sv/bptc_div64.sv =====
// Unsigned 64/64 restoring divider, one quotient bit per pipeline stage.
// Depends on bptc_pkg for the stage count.
module bptc_div64
	import bptc_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic [63:0] quotient
);
	logic [63:0] rem_q [DIV_STAGES];
	logic [63:0] num_q [DIV_STAGES];
	logic [63:0] den_q [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [63:0] rem_in;
		logic [63:0] num_in;
		logic [63:0] den_in;
		logic [64:0] trial;
		logic [64:0] diff;
		logic        take;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = dividend;
			assign den_in = divisor;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign num_in = num_q[i-1];
			assign den_in = den_q[i-1];
		end

		always_comb begin
			trial = {rem_in, num_in[63]};
			diff  = trial - {1'b0, den_in};
			take  = !diff[64];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= take ? diff[63:0] : trial[63:0];
				num_q[i] <= {num_in[62:0], take};
				den_q[i] <= den_in;
			end
		end
	end

	assign quotient = num_q[DIV_STAGES-1];
endmodule

// ===== sv/bptc_front.sv =====
// Front end: accepts raw samples and computes fine temperature and 0.01 degC value.
// Depends on bptc_pkg and bptc_stream_if.
module bptc_front
	import bptc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	bptc_stream_if.sink          samples,
	input  calib_t               calib,
	input  logic                 queue_full,
	output logic                 push,
	output queue_entry_t         push_data
);
	logic                adv;
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [19:0]         adc_t;
	logic signed [18:0]  a_s1;
	logic signed [16:0]  b_s1;
	logic [20:0]         pp_s1, pp_s2, pp_s3, pp_s4;
	logic signed [34:0]  v1p_s2;
	logic [31:0]         bb_s2;
	logic signed [23:0]  v1_s3;
	logic signed [38:0]  v2p_s3;
	logic signed [31:0]  fine_c;
	logic signed [35:0]  t5;
	logic signed [35:0]  tcw;
	logic signed [15:0]  tc_c;
	logic signed [31:0]  fine_s4;
	logic signed [15:0]  tc_s4;

	// hold the whole front only when the last stage cannot drain
	assign adv = !(v_s4 && queue_full);
	assign samples.ready = adv;
	assign adc_t = samples.data.raw_temperature[23:4];

	always_comb begin
		fine_c = 32'(v1_s3) + 32'(v2p_s3 >>> 14);
		t5 = (36'(fine_c) <<< 2) + 36'(fine_c) + 36'sd128;
		tcw = t5 >>> 8;
		if (tcw > 36'sd32767) begin
			tc_c = 16'sh7fff;
		end else if (tcw < -36'sd32768) begin
			tc_c = 16'sh8000;
		end else begin
			tc_c = tcw[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, calib.t1, 1'b0});
			b_s1    <= $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, calib.t1});
			pp_s1   <= ADC_FULL - {1'b0, samples.data.raw_pressure[23:4]};
			v1p_s2  <= a_s1 * calib.t2;
			bb_s2   <= 32'(b_s1 * b_s1);
			pp_s2   <= pp_s1;
			v1_s3   <= v1p_s2[34:11];
			v2p_s3  <= $signed({1'b0, bb_s2[31:12]}) * calib.t3;
			pp_s3   <= pp_s2;
			fine_s4 <= fine_c;
			tc_s4   <= tc_c;
			pp_s4   <= pp_s3;
		end
	end

	assign push = v_s4 && !queue_full;
	assign push_data = '{fine: fine_s4, tc: tc_s4, pp: pp_s4};
endmodule

// ===== sv/bptc_back.sv =====
// Back end: 64-bit pressure polynomial, pipelined divide, conversion to hPa.
// Depends on bptc_pkg, bptc_stream_if, bptc_mul64 and bptc_div64.
module bptc_back
	import bptc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  calib_t        calib,
	input  logic          queue_valid,
	input  queue_entry_t  queue_data,
	output logic          pop,
	bptc_stream_if.source results
);
	localparam int DivIn = 10;
	localparam int DivOut = DivIn + DIV_STAGES;
	localparam int Last = DivOut + 10;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] fine;
		logic signed [15:0] tc;
		logic        [20:0] pp;
		logic               neg;
		logic               dz;
	} side_t;

	logic        adv;
	side_t       side_q [1:Last];
	side_t       div_side;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [63:0] x1_s1;
	logic [63:0] m1, m2, m3, m2_s4, m2_s5, m3_s4, m3_s5;
	logic [63:0] m1p6, m1p3;
	logic [63:0] x2_s6, x1b_s6, n0_s7;
	logic [63:0] k_p, num_p, x1c_s9;
	logic [63:0] a_mag_s10, d_mag_s10;
	logic [63:0] quo;
	logic [63:0] pd_s75, pd_s76, pd_s77, pd_s78, pd_s79;
	logic [63:0] q_s75;
	logic [63:0] qq, p8pd, y1p, p8pd_s78, p8pd_s79;
	logic [63:0] sum_s80, p_s81;
	logic [20:0] n_s82;
	logic        zero_s82, sat_s82, zero_s83, sat_s83;
	logic [42:0] prod_s83;
	logic [15:0] hpa_s84;

	assign adv = !results.valid || results.ready;
	assign pop = adv && queue_valid;

	assign p1 = {48'd0, calib.p1};
	assign p2 = 64'(calib.p2);
	assign p3 = 64'(calib.p3);
	assign p4 = 64'(calib.p4);
	assign p5 = 64'(calib.p5);
	assign p6 = 64'(calib.p6);
	assign p7 = 64'(calib.p7);
	assign p8 = 64'(calib.p8);
	assign p9 = 64'(calib.p9);

	// sign and zero checks of the divide ride with the item
	always_comb begin
		div_side     = side_q[DivIn-1];
		div_side.neg = num_p[63] ^ x1c_s9[63];
		div_side.dz  = (x1c_s9 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= Last; k++) begin
				side_q[k] <= '0;
			end
		end else if (adv) begin
			side_q[1] <= '{valid: queue_valid, fine: queue_data.fine, tc: queue_data.tc,
				pp: queue_data.pp, neg: 1'b0, dz: 1'b0};
			for (int k = 2; k <= Last; k++) begin
				side_q[k] <= (k == DivIn) ? div_side : side_q[k-1];
			end
		end
	end

	bptc_mul64 u_mul_x1x1 (.clk, .en(adv), .a(x1_s1), .b(x1_s1), .p(m1));
	bptc_mul64 u_mul_x1p5 (.clk, .en(adv), .a(x1_s1), .b(p5), .p(m2));
	bptc_mul64 u_mul_x1p2 (.clk, .en(adv), .a(x1_s1), .b(p2), .p(m3));
	bptc_mul64 u_mul_p6 (.clk, .en(adv), .a(m1), .b(p6), .p(m1p6));
	bptc_mul64 u_mul_p3 (.clk, .en(adv), .a(m1), .b(p3), .p(m1p3));
	bptc_mul64 u_mul_p1 (.clk, .en(adv), .a(x1b_s6), .b(p1), .p(k_p));
	bptc_mul64 u_mul_3125 (.clk, .en(adv), .a(n0_s7), .b(SCALE_3125), .p(num_p));
	bptc_div64 u_div (.clk, .en(adv), .dividend(a_mag_s10), .divisor(d_mag_s10),
		.quotient(quo));
	bptc_mul64 u_mul_qq (.clk, .en(adv), .a(q_s75), .b(q_s75), .p(qq));
	bptc_mul64 u_mul_p8 (.clk, .en(adv), .a(pd_s75), .b(p8), .p(p8pd));
	bptc_mul64 u_mul_p9 (.clk, .en(adv), .a(qq), .b(p9), .p(y1p));

	assign q_s75 = 64'($signed(pd_s75) >>> 13);

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1     <= 64'(queue_data.fine) - FINE_OFFSET;
			m2_s4     <= m2;
			m2_s5     <= m2_s4;
			m3_s4     <= m3;
			m3_s5     <= m3_s4;
			x2_s6     <= m1p6 + (m2_s5 << 17) + (p4 << 35);
			x1b_s6    <= 64'($signed(m1p3) >>> 8) + (m3_s5 << 12) + ONE_SHL47;
			n0_s7     <= {12'd0, side_q[6].pp, 31'd0} - x2_s6;
			x1c_s9    <= 64'($signed(k_p) >>> 33);
			a_mag_s10 <= num_p[63] ? -num_p : num_p;
			d_mag_s10 <= x1c_s9[63] ? -x1c_s9 : x1c_s9;
			pd_s75    <= side_q[DivOut].neg ? -quo : quo;
			pd_s76    <= pd_s75;
			pd_s77    <= pd_s76;
			pd_s78    <= pd_s77;
			pd_s79    <= pd_s78;
			p8pd_s78  <= p8pd;
			p8pd_s79  <= p8pd_s78;
			sum_s80   <= pd_s79 + 64'($signed(y1p) >>> 25) + 64'($signed(p8pd_s79) >>> 19);
			p_s81     <= 64'($signed(sum_s80) >>> 8) + (p7 << 4);
			zero_s82  <= side_q[Last-3].dz || p_s81[63] || (p_s81 == '0);
			sat_s82   <= !p_s81[63] && (p_s81 >= HPA_SAT_PA);
			n_s82     <= p_s81[30:10];
			zero_s83  <= zero_s82;
			sat_s83   <= sat_s82;
			prod_s83  <= n_s82 * RECIP_25;
			if (zero_s83) begin
				hpa_s84 <= '0;
			end else if (sat_s83) begin
				hpa_s84 <= 16'hffff;
			end else begin
				hpa_s84 <= prod_s83[41:26];
			end
		end
	end

	assign results.valid = side_q[Last].valid;
	assign results.data = '{temperature_centi: side_q[Last].tc,
		fine_temperature: side_q[Last].fine, pressure_hpa: hpa_s84,
		divide_error: side_q[Last].dz};
endmodule

// ===== test/baro_temp_pressure_compensation_top_tb.sv =====
// Testbench for baro_temp_pressure_compensation_top: a directed table of samples and
// calibration writes, then randomized phases, checked against a behavioral predictor or fixed expected results.
// Depends on bptc_pkg, bptc_stream_if and the block under test.
module baro_temp_pressure_compensation_top_tb;
	import bptc_pkg::*;

	typedef struct {
		bit          is_cfg;
		reg_index_t  idx;
		logic [63:0] wdata;
		sample_t     smp;
		bit          fixed;
		result_t     res;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	bptc_stream_if #(.T(sample_t))    samples ();
	bptc_stream_if #(.T(result_t))    results ();
	bptc_stream_if #(.T(cfg_write_t)) cfg ();

	baro_temp_pressure_compensation_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	// calibration as the predictor sees it
	logic [47:0] temp_cal;
	logic [63:0] press_a;
	logic [63:0] press_b;
	logic [15:0] press_p9;

	result_t pending_results[$];
	step_t   directed_steps[$];
	int      err_count;
	int      n_samples;
	int      n_results;
	int      n_div_err;
	int      n_cfg;
	bit      quiet;
	int      ready_left;

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic result_t compensate(sample_t s);
		longint  adc_t, adc_p, t1, t2, t3, a, v1, b, v2, fine, tc;
		longint  p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint  x1, x2, p, q, y1, y2, num, h;
		logic [31:0] fu;
		result_t r;
		adc_t = longint'(s.raw_temperature[23:4]);
		adc_p = longint'(s.raw_pressure[23:4]);
		t1 = longint'(temp_cal[15:0]);
		t2 = longint'($signed(temp_cal[31:16]));
		t3 = longint'($signed(temp_cal[47:32]));
		a  = (adc_t >>> 3) - t1 * 2;
		v1 = (a * t2) >>> 11;
		b  = (adc_t >>> 4) - t1;
		v2 = (((b * b) >>> 12) * t3) >>> 14;
		fu = 32'(v1 + v2);
		fine = longint'($signed(fu));
		tc = (fine * 5 + 128) >>> 8;
		if (tc > 32767) tc = 32767;
		if (tc < -32768) tc = -32768;
		r.temperature_centi = tc[15:0];
		r.fine_temperature  = fu;

		p1 = longint'(press_a[15:0]);
		p2 = longint'($signed(press_a[31:16]));
		p3 = longint'($signed(press_a[47:32]));
		p4 = longint'($signed(press_a[63:48]));
		p5 = longint'($signed(press_b[15:0]));
		p6 = longint'($signed(press_b[31:16]));
		p7 = longint'($signed(press_b[47:32]));
		p8 = longint'($signed(press_b[63:48]));
		p9 = longint'($signed(press_p9));

		x1 = fine - 128000;
		x2 = x1 * x1 * p6;
		x2 = x2 + ((x1 * p5) << 17);
		x2 = x2 + (p4 << 35);
		x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
		x1 = (((64'sd1 << 47) + x1) * p1) >>> 33;

		r.pressure_hpa = 16'd0;
		r.divide_error = 1'b0;
		if (x1 == 0) begin
			r.divide_error = 1'b1;
		end else begin
			p = 1048576 - adc_p;
			num = ((p << 31) - x2) * 3125;
			// most negative over minus one wraps back to itself
			if (num == 64'sh8000_0000_0000_0000 && x1 == -1)
				p = num;
			else
				p = num / x1;
			q  = p >>> 13;
			y1 = (p9 * q * q) >>> 25;
			y2 = (p8 * p) >>> 19;
			p  = ((p + y1 + y2) >>> 8) + (p7 << 4);
			if (p > 0) begin
				h = p / 25600;
				r.pressure_hpa = (h > 65535) ? 16'hFFFF : h[15:0];
			end
		end
		return r;
	endfunction

	function automatic step_t row_cfg(reg_index_t idx, logic [63:0] v);
		step_t st;
		st = '{idx: REG_TEMP_CALIB, default: '0};
		st.is_cfg = 1'b1;
		st.idx    = idx;
		st.wdata  = v;
		return st;
	endfunction

	function automatic step_t row_smp(logic [23:0] t, logic [23:0] p);
		step_t st;
		st = '{idx: REG_TEMP_CALIB, default: '0};
		st.smp = '{raw_temperature: t, raw_pressure: p};
		return st;
	endfunction

	function automatic step_t row_fixed(logic [23:0] t, logic [23:0] p, result_t r);
		step_t st;
		st = row_smp(t, p);
		st.fixed = 1'b1;
		st.res   = r;
		return st;
	endfunction

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [63:0] v);
		bit got;
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= '{index: idx, wdata: v};
		do begin
			@(negedge clk);
			got = cfg.ready;
			@(posedge clk);
		end while (!got);
		cfg.valid <= 1'b0;
		case (idx)
			REG_TEMP_CALIB:  temp_cal = v[47:0];
			REG_PRESS_CAL_A: press_a  = v;
			REG_PRESS_CAL_B: press_b  = v;
			REG_PRESS_P9:    press_p9 = v[15:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// send one request; the expectation goes in at the accepting edge
	task automatic send_sample(sample_t s, bit fixed, result_t fixed_res);
		bit got;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.data  <= s;
		do begin
			@(negedge clk);
			got = samples.ready;
			@(posedge clk);
		end while (!got);
		pending_results.push_back(fixed ? fixed_res : compensate(s));
		n_samples++;
	endtask

	task automatic idle_sender();
		samples.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side stalls in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			ready_left <= 0;
			results.ready <= 1'b0;
		end else if (ready_left == 0) begin
			ready_left <= $urandom_range(1, 19);
			results.ready <= quiet ? 1'b1 : ($urandom_range(0, 1) == 1);
		end else begin
			ready_left <= ready_left - 1;
		end
	end

	always @(negedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && results.valid && results.ready) begin
			got = results.data;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (got.divide_error) n_div_err++;
				if (got.temperature_centi !== want.temperature_centi) begin
					$display("%0t: temperature_centi expected %0d got %0d", $time,
						want.temperature_centi, got.temperature_centi);
					err_count++;
				end
				if (got.fine_temperature !== want.fine_temperature) begin
					$display("%0t: fine_temperature expected %0d got %0d", $time,
						want.fine_temperature, got.fine_temperature);
					err_count++;
				end
				if (got.pressure_hpa !== want.pressure_hpa) begin
					$display("%0t: pressure_hpa expected %0d got %0d", $time,
						want.pressure_hpa, got.pressure_hpa);
					err_count++;
				end
				if (got.divide_error !== want.divide_error) begin
					$display("%0t: divide_error expected %0b got %0b", $time,
						want.divide_error, got.divide_error);
					err_count++;
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [15:0] jitter(int base, int span);
		return 16'(base + $urandom_range(0, 2 * span) - span);
	endfunction

	initial begin
		result_t zero_cal;
		step_t   st;
		sample_t s;
		int      kind;
		int      count;
		logic [19:0] at;
		logic [19:0] ap;

		arst_n        <= 1'b0;
		samples.valid <= 1'b0;
		samples.data  <= '0;
		cfg.valid     <= 1'b0;
		cfg.data      <= '{index: REG_TEMP_CALIB, wdata: 64'd0};
		quiet         = 1'b0;
		err_count     = 0;
		n_samples     = 0;
		n_results     = 0;
		n_div_err     = 0;
		n_cfg         = 0;
		temp_cal      = '0;
		press_a       = '0;
		press_b       = '0;
		press_p9      = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all calibration zero: fine is zero and the divisor is zero
		zero_cal = '{temperature_centi: 16'sd0, fine_temperature: 32'sd0,
			pressure_hpa: 16'd0, divide_error: 1'b1};
		directed_steps.push_back(row_fixed(24'h000000, 24'h000000, zero_cal));
		directed_steps.push_back(row_fixed(24'hFFFFFF, 24'hFFFFFF, zero_cal));
		directed_steps.push_back(row_fixed(24'h7EED0F, 24'h655AC0, zero_cal));
		directed_steps.push_back(row_cfg(REG_TEMP_CALIB, {16'hFC18, 16'd26435, 16'd27504}));
		directed_steps.push_back(row_cfg(REG_PRESS_CAL_A,
			{16'd2855, 16'd3024, 16'hD443, 16'd36477}));
		directed_steps.push_back(row_cfg(REG_PRESS_CAL_B,
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}));
		directed_steps.push_back(row_cfg(REG_PRESS_P9, 64'd6000));
		directed_steps.push_back(row_smp({20'd519888, 4'h0}, {20'd415148, 4'h0}));
		directed_steps.push_back(row_smp(24'h000000, 24'h000000));
		directed_steps.push_back(row_smp(24'hFFFFFF, 24'hFFFFFF));
		directed_steps.push_back(row_smp(24'h000000, 24'hFFFFFF));
		directed_steps.push_back(row_smp(24'hFFFFFF, 24'h000000));
		directed_steps.push_back(row_smp(24'h80000F, 24'h7FFFF0));
		// P1 of zero: divisor zero while temperature stays valid
		directed_steps.push_back(row_cfg(REG_PRESS_CAL_A,
			{16'd2855, 16'd3024, 16'hD443, 16'd0}));
		directed_steps.push_back(row_smp({20'd519888, 4'h5}, {20'd415148, 4'hA}));
		// tiny divisor drives pressure into saturation
		directed_steps.push_back(row_cfg(REG_PRESS_CAL_A, 64'd1));
		directed_steps.push_back(row_cfg(REG_PRESS_CAL_B, 64'd0));
		directed_steps.push_back(row_cfg(REG_PRESS_P9, 64'd0));
		directed_steps.push_back(row_smp({20'd519888, 4'h0}, 24'h000000));
		// negative P7 with almost no pressure margin clamps to zero
		directed_steps.push_back(row_cfg(REG_PRESS_CAL_A, 64'h0000_0000_0000_FFFF));
		directed_steps.push_back(row_cfg(REG_PRESS_CAL_B, 64'h0000_8000_0000_0000));
		directed_steps.push_back(row_smp({20'd519888, 4'h0}, 24'hFFFFF0));
		directed_steps.push_back(row_cfg(REG_TEMP_CALIB, 64'h0000_7FFF_8000_FFFF));
		directed_steps.push_back(row_smp(24'hFFFFFF, 24'h123456));
		directed_steps.push_back(row_smp(24'h000000, 24'hEDCBA9));

		foreach (directed_steps[i]) begin
			st = directed_steps[i];
			if (st.is_cfg) begin
				idle_sender();
				write_reg(st.idx, st.wdata);
			end else begin
				send_sample(st.smp, st.fixed, st.res);
			end
		end
		idle_sender();

		for (int ph = 0; ph < 9; ph++) begin
			kind = (ph < 5) ? ph : $urandom_range(0, 1);
			if (ph == 8) quiet = 1'b1;
			case (kind)
				0: begin
					write_reg(REG_TEMP_CALIB, {jitter(-1000, 300), jitter(26435, 2000),
						jitter(27504, 2000)});
					write_reg(REG_PRESS_CAL_A, {jitter(2855, 500), jitter(3024, 500),
						jitter(-10685, 1000), jitter(36477, 3000)});
					write_reg(REG_PRESS_CAL_B, {jitter(-14600, 1000), jitter(15500, 1000),
						jitter(-7, 5), jitter(140, 50)});
					write_reg(REG_PRESS_P9, 64'(jitter(6000, 500)));
				end
				1: begin
					write_reg(REG_TEMP_CALIB, rand64());
					write_reg(REG_PRESS_CAL_A, rand64());
					write_reg(REG_PRESS_CAL_B, rand64());
					write_reg(REG_PRESS_P9, rand64());
				end
				2: begin
					write_reg(REG_TEMP_CALIB, {64{1'b1}});
					write_reg(REG_PRESS_CAL_A, {64{1'b1}});
					write_reg(REG_PRESS_CAL_B, {64{1'b1}});
					write_reg(REG_PRESS_P9, {64{1'b1}});
				end
				3: begin
					write_reg(REG_TEMP_CALIB, 64'h0000_8000_7FFF_FFFF);
					write_reg(REG_PRESS_CAL_A, 64'h7FFF_8000_7FFF_FFFF);
					write_reg(REG_PRESS_CAL_B, 64'h8000_7FFF_8000_7FFF);
					write_reg(REG_PRESS_P9, 64'h0000_0000_0000_8000);
				end
				default: begin
					write_reg(REG_TEMP_CALIB, 64'd0);
					write_reg(REG_PRESS_CAL_A, 64'd0);
					write_reg(REG_PRESS_CAL_B, 64'd0);
					write_reg(REG_PRESS_P9, 64'h0000_0000_0000_7FFF);
				end
			endcase
			count = 58 + $urandom_range(0, 8);
			for (int k = 0; k < count; k++) begin
				if ($urandom_range(0, 4) != 0) begin
					at = 20'($urandom_range(380000, 640000));
					ap = 20'($urandom_range(200000, 600000));
					s.raw_temperature = {at, 4'($urandom())};
					s.raw_pressure    = {ap, 4'($urandom())};
				end else begin
					s.raw_temperature = 24'($urandom());
					s.raw_pressure    = 24'($urandom());
				end
				send_sample(s, 1'b0, '0);
				// hold the sender once until the pipeline is empty
				if (ph == 4 && k == count / 2) begin
					idle_sender();
					drain();
				end
			end
			idle_sender();
		end

		drain();
		repeat (120) @(posedge clk);
		$display("Sent %0d samples and %0d calibration writes; %0d results checked",
			n_samples, n_cfg, n_results);
		$display("%0d results flagged a zero divisor", n_div_err);
		if (err_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
